/* hdl/ragm_pkg.sv */
// Shared types and constants of the range-add / global-maximum tree.
package ragm_pkg;

    localparam int RANGE_W   = 10;
    localparam int DELTA_W   = 32;
    localparam int RESULT_W  = 32;

    localparam int S_LOW_LSB   = 0;
    localparam int S_HIGH_LSB  = S_LOW_LSB + RANGE_W;
    localparam int S_DELTA_LSB = S_HIGH_LSB + RANGE_W;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 32;

    // Datapath commands issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_RD_CUR,
        OP_LD_CUR,
        OP_LD_ROOT,
        OP_RD_LEFT,
        OP_PUSH_L,
        OP_PUSH_R,
        OP_COVER,
        OP_DESCEND,
        OP_ASCEND,
        OP_FIX_A,
        OP_FIX_B,
        OP_FIX_C,
        OP_OUTPUT
    } op_t;

    // Datapath status seen by the controller.
    typedef struct packed {
        logic clear_last;
        logic empty;
        logic covered;
        logic leaf;
        logic pend_nz;
        logic stack_empty;
        logic can_right;
    } status_t;

endpackage

/* hdl/ragm_datapath.sv */
// Datapath of the tree: node memory, traversal stack and saturating arithmetic.
module ragm_datapath #(
    parameter int NUM_POSITIONS = 1024,
    parameter int VALUE_WIDTH   = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ragm_pkg::op_t                       op,
    input  logic [ragm_pkg::RANGE_W-1:0]        range_low,
    input  logic [ragm_pkg::RANGE_W-1:0]        range_high,
    input  logic signed [ragm_pkg::DELTA_W-1:0] delta,
    output ragm_pkg::status_t                   status,
    output logic [ragm_pkg::RESULT_W-1:0]       global_max
);

    localparam int VW      = VALUE_WIDTH;
    localparam int ENT_W   = 2 * VW;
    localparam int EW      = (VW > ragm_pkg::DELTA_W) ? VW : ragm_pkg::DELTA_W;
    localparam int POS_W   = $clog2(NUM_POSITIONS);
    localparam int NODE_W  = POS_W + 1;
    localparam int DEPTH   = 2 ** NODE_W;
    localparam int LAST    = NUM_POSITIONS - 1;
    localparam int CW      = (POS_W > ragm_pkg::RANGE_W) ? POS_W : ragm_pkg::RANGE_W;
    localparam int STACK_D = POS_W;
    localparam int STK_IW  = (STACK_D > 1) ? $clog2(STACK_D) : 1;
    localparam int SP_W    = $clog2(STACK_D + 1);

    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW - 1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW - 1){1'b0}}};
    localparam logic [NODE_W-1:0]    ROOT = NODE_W'(1);

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [POS_W-1:0]  lo;
        logic [POS_W-1:0]  hi;
        logic              went_right;
    } frame_t;

    function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] a,
                                                     input logic signed [VW-1:0] b);
        logic signed [VW:0] sum;
        sum = {a[VW-1], a} + {b[VW-1], b};
        if (sum[VW] != sum[VW-1]) begin
            sat_add = sum[VW] ? VMIN : VMAX;
        end else begin
            sat_add = sum[VW-1:0];
        end
    endfunction

    // Each entry holds the node maximum in the upper half and the pending add below.
    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] rdata_reg;
    logic             mem_we;
    logic             mem_re;
    logic [NODE_W-1:0] mem_waddr;
    logic [NODE_W-1:0] mem_raddr;
    logic [ENT_W-1:0] mem_wdata;

    logic [NODE_W-1:0]     clear_addr_reg;
    logic [SP_W-1:0]       sp_reg;
    logic [CW-1:0]         ql_reg;
    logic [CW-1:0]         qh_reg;
    logic signed [VW-1:0]  delta_reg;
    logic [NODE_W-1:0]     cur_node_reg;
    logic [POS_W-1:0]      cur_lo_reg;
    logic [POS_W-1:0]      cur_hi_reg;
    logic signed [VW-1:0]  ent_max_reg;
    logic signed [VW-1:0]  ent_pend_reg;
    logic signed [VW-1:0]  lmax_reg;
    logic signed [VW-1:0]  last_max_reg;
    logic [ragm_pkg::RESULT_W-1:0] out_reg;
    frame_t                stack_reg [STACK_D];

    logic signed [VW-1:0] rd_max;
    logic signed [VW-1:0] rd_pend;
    logic signed [VW-1:0] cover_max;
    logic signed [VW-1:0] fix_max;
    logic [ENT_W-1:0]     push_word;
    logic [NODE_W-1:0]    cur_left;
    logic [NODE_W-1:0]    cur_right;
    logic [POS_W:0]       cur_sum;
    logic [POS_W-1:0]     cur_mid;
    logic                 go_left;
    logic [SP_W-1:0]      sp_dec;
    logic [STK_IW-1:0]    top_idx;
    logic [STK_IW-1:0]    push_idx;
    frame_t               top;
    logic [POS_W:0]       top_sum;
    logic [POS_W-1:0]     top_mid;
    logic                 can_right;
    logic [CW-1:0]        qh_in;
    logic [CW-1:0]        qh_clip;
    logic signed [EW-1:0] d_ext;
    logic signed [EW-1:0] vmax_ext;
    logic signed [EW-1:0] vmin_ext;
    logic signed [VW-1:0] d_clamp;
    logic signed [EW-1:0] out_ext;

    assign rd_max    = $signed(rdata_reg[ENT_W-1:VW]);
    assign rd_pend   = $signed(rdata_reg[VW-1:0]);
    assign cover_max = sat_add(ent_max_reg, delta_reg);
    assign fix_max   = (lmax_reg > rd_max) ? lmax_reg : rd_max;
    assign push_word = {sat_add(rd_max, ent_pend_reg), sat_add(rd_pend, ent_pend_reg)};

    assign cur_left  = {cur_node_reg[NODE_W-2:0], 1'b0};
    assign cur_right = {cur_node_reg[NODE_W-2:0], 1'b1};
    assign cur_sum   = {1'b0, cur_lo_reg} + {1'b0, cur_hi_reg};
    assign cur_mid   = cur_sum[POS_W:1];
    assign go_left   = ql_reg <= CW'(cur_mid);

    assign sp_dec    = sp_reg - SP_W'(1);
    assign top_idx   = sp_dec[STK_IW-1:0];
    assign push_idx  = sp_reg[STK_IW-1:0];
    assign top       = stack_reg[top_idx];
    assign top_sum   = {1'b0, top.lo} + {1'b0, top.hi};
    assign top_mid   = top_sum[POS_W:1];
    assign can_right = (sp_reg != '0) && !top.went_right && (qh_reg > CW'(top_mid));

    // The high end is clipped to the last position; the low end is kept as given.
    assign qh_in   = CW'(range_high);
    assign qh_clip = (qh_in > CW'(LAST)) ? CW'(LAST) : qh_in;

    assign d_ext    = EW'(delta);
    assign vmax_ext = EW'(VMAX);
    assign vmin_ext = EW'(VMIN);
    always_comb begin
        if (d_ext > vmax_ext) begin
            d_clamp = VMAX;
        end else if (d_ext < vmin_ext) begin
            d_clamp = VMIN;
        end else begin
            d_clamp = d_ext[VW-1:0];
        end
    end

    assign out_ext = EW'(last_max_reg);

    assign status.clear_last  = &clear_addr_reg;
    assign status.empty       = ql_reg > qh_reg;
    assign status.covered     = (CW'(cur_lo_reg) >= ql_reg) && (CW'(cur_hi_reg) <= qh_reg);
    assign status.leaf        = cur_lo_reg == cur_hi_reg;
    assign status.pend_nz     = rd_pend != '0;
    assign status.stack_empty = sp_reg == '0;
    assign status.can_right   = can_right;

    assign global_max = out_reg;

    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = cur_node_reg;
        mem_raddr = cur_node_reg;
        mem_wdata = push_word;
        case (op)
            ragm_pkg::OP_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clear_addr_reg;
                mem_wdata = '0;
            end
            ragm_pkg::OP_RD_CUR: begin
                mem_re = 1'b1;
            end
            ragm_pkg::OP_RD_LEFT, ragm_pkg::OP_FIX_A: begin
                mem_re    = 1'b1;
                mem_raddr = cur_left;
            end
            ragm_pkg::OP_PUSH_L: begin
                mem_we    = 1'b1;
                mem_waddr = cur_left;
                mem_re    = 1'b1;
                mem_raddr = cur_right;
            end
            ragm_pkg::OP_PUSH_R: begin
                mem_we    = 1'b1;
                mem_waddr = cur_right;
            end
            ragm_pkg::OP_COVER: begin
                mem_we    = 1'b1;
                mem_wdata = {cover_max, delta_reg};
            end
            ragm_pkg::OP_FIX_B: begin
                mem_re    = 1'b1;
                mem_raddr = cur_right;
            end
            ragm_pkg::OP_FIX_C: begin
                mem_we    = 1'b1;
                mem_wdata = {fix_max, {VW{1'b0}}};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_addr_reg <= '0;
            sp_reg         <= '0;
        end else begin
            if (op == ragm_pkg::OP_CLEAR) begin
                clear_addr_reg <= clear_addr_reg + NODE_W'(1);
            end
            if (op == ragm_pkg::OP_DESCEND) begin
                sp_reg <= sp_reg + SP_W'(1);
            end else if (op == ragm_pkg::OP_ASCEND && sp_reg != '0 && !can_right) begin
                sp_reg <= sp_dec;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (op)
            ragm_pkg::OP_LOAD: begin
                ql_reg       <= CW'(range_low);
                qh_reg       <= qh_clip;
                delta_reg    <= d_clamp;
                cur_node_reg <= ROOT;
                cur_lo_reg   <= '0;
                cur_hi_reg   <= POS_W'(LAST);
            end
            ragm_pkg::OP_LD_CUR: begin
                ent_max_reg  <= rd_max;
                ent_pend_reg <= rd_pend;
            end
            ragm_pkg::OP_LD_ROOT: begin
                last_max_reg <= rd_max;
            end
            ragm_pkg::OP_COVER: begin
                last_max_reg <= cover_max;
            end
            ragm_pkg::OP_DESCEND: begin
                stack_reg[push_idx] <= '{node: cur_node_reg, lo: cur_lo_reg,
                                         hi: cur_hi_reg, went_right: !go_left};
                if (go_left) begin
                    cur_node_reg <= cur_left;
                    cur_hi_reg   <= cur_mid;
                end else begin
                    cur_node_reg <= cur_right;
                    cur_lo_reg   <= cur_mid + POS_W'(1);
                end
            end
            ragm_pkg::OP_ASCEND: begin
                if (sp_reg != '0) begin
                    if (can_right) begin
                        // Left subtree finished; the parent stays on the stack.
                        stack_reg[top_idx].went_right <= 1'b1;
                        cur_node_reg <= {top.node[NODE_W-2:0], 1'b1};
                        cur_lo_reg   <= top_mid + POS_W'(1);
                        cur_hi_reg   <= top.hi;
                    end else begin
                        cur_node_reg <= top.node;
                        cur_lo_reg   <= top.lo;
                        cur_hi_reg   <= top.hi;
                    end
                end
            end
            ragm_pkg::OP_FIX_B: begin
                lmax_reg <= rd_max;
            end
            ragm_pkg::OP_FIX_C: begin
                last_max_reg <= fix_max;
            end
            ragm_pkg::OP_OUTPUT: begin
                out_reg <= out_ext[ragm_pkg::RESULT_W-1:0];
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_cover_only_when_covered: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == ragm_pkg::OP_COVER) |-> status.covered)
        else $error("covering write on a node outside the range");
    a_descend_not_leaf: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == ragm_pkg::OP_DESCEND) |-> (!status.leaf && sp_reg < SP_W'(STACK_D)))
        else $error("descent from a leaf or past the stack depth");
    a_span_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == ragm_pkg::OP_RD_CUR) |-> (cur_lo_reg <= cur_hi_reg))
        else $error("node span has its low end above its high end");
`endif

endmodule

/* hdl/ragm_ctrl.sv */
// Controller state machine that sequences the tree walk and the result handshake.
module ragm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  ragm_pkg::status_t  status,
    output ragm_pkg::op_t      op
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NODE_RD,
        ST_GET_ROOT,
        ST_GET_NODE,
        ST_PUSH_RD,
        ST_PUSH_L,
        ST_PUSH_R,
        ST_COVER,
        ST_DESCEND,
        ST_ASCEND,
        ST_FIX_A,
        ST_FIX_B,
        ST_FIX_C,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        op            = ragm_pkg::OP_NONE;
        case (state_reg)
            ST_CLEAR: begin
                op = ragm_pkg::OP_CLEAR;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    op         = ragm_pkg::OP_LOAD;
                    state_next = ST_NODE_RD;
                end
            end
            ST_NODE_RD: begin
                op         = ragm_pkg::OP_RD_CUR;
                state_next = status.empty ? ST_GET_ROOT : ST_GET_NODE;
            end
            ST_GET_ROOT: begin
                op         = ragm_pkg::OP_LD_ROOT;
                state_next = ST_DONE;
            end
            ST_GET_NODE: begin
                op = ragm_pkg::OP_LD_CUR;
                if (status.pend_nz && !status.leaf) begin
                    state_next = ST_PUSH_RD;
                end else if (status.covered) begin
                    state_next = ST_COVER;
                end else begin
                    state_next = ST_DESCEND;
                end
            end
            ST_PUSH_RD: begin
                op         = ragm_pkg::OP_RD_LEFT;
                state_next = ST_PUSH_L;
            end
            ST_PUSH_L: begin
                op         = ragm_pkg::OP_PUSH_L;
                state_next = ST_PUSH_R;
            end
            ST_PUSH_R: begin
                op         = ragm_pkg::OP_PUSH_R;
                state_next = status.covered ? ST_COVER : ST_DESCEND;
            end
            ST_COVER: begin
                op         = ragm_pkg::OP_COVER;
                state_next = ST_ASCEND;
            end
            ST_DESCEND: begin
                op         = ragm_pkg::OP_DESCEND;
                state_next = ST_NODE_RD;
            end
            ST_ASCEND: begin
                op = ragm_pkg::OP_ASCEND;
                if (status.stack_empty) begin
                    state_next = ST_DONE;
                end else if (status.can_right) begin
                    state_next = ST_NODE_RD;
                end else begin
                    state_next = ST_FIX_A;
                end
            end
            ST_FIX_A: begin
                op         = ragm_pkg::OP_FIX_A;
                state_next = ST_FIX_B;
            end
            ST_FIX_B: begin
                op         = ragm_pkg::OP_FIX_B;
                state_next = ST_FIX_C;
            end
            ST_FIX_C: begin
                op         = ragm_pkg::OP_FIX_C;
                state_next = ST_ASCEND;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    op            = ragm_pkg::OP_OUTPUT;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

`ifndef SYNTHESIS
    a_done_at_root: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> status.stack_empty)
        else $error("walk finished with ancestors still on the stack");
    a_output_raises_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == ragm_pkg::OP_OUTPUT) |=> m_tvalid_reg)
        else $error("result loaded without a valid beat");
`endif

endmodule

/* hdl/range_add_global_max_tree.sv */
// Top level of the range-add / global-maximum lazy segment tree.
// Each input beat adds a signed delta, saturated at the VALUE_WIDTH signed limits, to every
// position of an inclusive range and returns one beat with the largest value over all
// positions. Node maximums and pending adds live in one single-port-write, registered-read
// memory of 2 * 2**ceil(log2(NUM_POSITIONS)) entries, and the walk is a depth-first pass
// with an explicit stack, at most one memory read and one memory write per cycle. Each visited
// node is read and loaded, optionally pushes its pending add into both children (read left,
// write left while reading right, write right), then takes either a covering write or a
// descent and a later max fix-up (read left, read right, write), and then climbs back; an
// update visits at most about 4 * log2(NUM_POSITIONS) nodes between the accept and the
// output of its beat. After reset a clearing pass writes every entry, one per cycle, before
// the first beat is accepted.
module range_add_global_max_tree #(
    parameter int NUM_POSITIONS = 1024,
    parameter int VALUE_WIDTH   = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // range_low [9:0], range_high [19:10], delta [51:20], zero fill [55:52]
    input  logic [ragm_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // global_max [31:0]
    output logic [ragm_pkg::M_TDATA_W-1:0]  m_tdata
);

    ragm_pkg::op_t                       op;
    ragm_pkg::status_t                   status;
    logic [ragm_pkg::RANGE_W-1:0]        range_low;
    logic [ragm_pkg::RANGE_W-1:0]        range_high;
    logic signed [ragm_pkg::DELTA_W-1:0] delta;
    logic [ragm_pkg::RESULT_W-1:0]       global_max;

    assign range_low  = s_tdata[ragm_pkg::S_LOW_LSB +: ragm_pkg::RANGE_W];
    assign range_high = s_tdata[ragm_pkg::S_HIGH_LSB +: ragm_pkg::RANGE_W];
    assign delta      = $signed(s_tdata[ragm_pkg::S_DELTA_LSB +: ragm_pkg::DELTA_W]);
    assign m_tdata    = ragm_pkg::M_TDATA_W'(global_max);

    ragm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .op       (op)
    );

    ragm_datapath #(
        .NUM_POSITIONS (NUM_POSITIONS),
        .VALUE_WIDTH   (VALUE_WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op         (op),
        .range_low  (range_low),
        .range_high (range_high),
        .delta      (delta),
        .status     (status),
        .global_max (global_max)
    );

endmodule
